// ===== design/ptt_pkg.sv =====
package ptt_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_ENABLE  = 3'd1;
    localparam logic [2:0] CMD_DISABLE = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_CHANGE  = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;
    localparam logic [2:0] CMD_RUN     = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_ZERO_PER  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;        // capture the input word
        logic       add_write;    // append entry to its group
        logic       tick;         // advance time by one
        logic       search_start; // start id search at the high group
        logic       next_group;   // move search on to the low group
        logic       run_start;    // start walking the chosen group
        logic       rd_issue;     // read entry at pos
        logic       rd_next;      // read entry at pos + 1
        logic       pos_inc;      // step pos
        logic       set_en;       // set enable bit at pos
        logic       clr_en;       // clear enable bit at pos
        logic       dl_rearm;     // deadline at pos = time + read period
        logic       wr_period;    // period at pos = input period
        logic       del_move;     // copy read entry down into pos
        logic       del_finish;   // clear last slot and shrink group
        logic       out_load;     // load the output register
        logic [1:0] out_status;
        logic       out_fired;
        logic       out_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       per_zero;
        logic       grp_full;
        logic       grp;
        logic       pos_lt_end;
        logic       pos1_lt_end;
        logic       match;
        logic       due;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== design/periodic_task_timer_table_top.sv =====
// Periodic task timer table.
// Input channel (i_valid / o_stall) takes one command word: add, enable,
// disable, delete, change period, tick or run, with task id, period, group
// and start enable. Output channel (o_valid / i_stall) returns result words:
// status, fired, fired task id and last. Every command ends with one word
// marked last; a run first gives one fired word per due enabled task.
// One command is worked at a time; o_stall is high from acceptance until the
// closing word has been loaded into the output register, so the next command
// may be taken at the following edge while that word still waits.
// Add, tick, unused and rejected commands go straight from decode to the
// closing word. A search compares entries one at a time, the hit included,
// first in the high group, then moving on to the low group; a miss walks
// both groups. Delete then moves each later entry down one slot. A run walks
// the chosen group. Each entry step is paced by the single entry memory read
// port with registered read data; without receiver stalls a miss over a full
// 16-entry table is among the longest commands.
// While the receiver stalls, the output word holds and a walk with a word to load waits.
// Reset clears time, both group counts, all enable bits and the output valid.
module periodic_task_timer_table_top #(
    parameter int HIGH_SLOTS  = 8,
    parameter int TOTAL_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_period,
    input  logic        i_priority_req,
    input  logic        i_start_enabled,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [7:0]  o_fired_task,
    output logic        o_last
);

    ptt_pkg::t_dp_cmd  dp_cmd;
    ptt_pkg::t_dp_stat dp_stat;

    // sequencer
    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // entry storage and output register
    ptt_dp #(
        .HIGH_SLOTS  (HIGH_SLOTS),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_task_id       (i_task_id),
        .i_period        (i_period),
        .i_priority_req  (i_priority_req),
        .i_start_enabled (i_start_enabled),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_fired         (o_fired),
        .o_fired_task    (o_fired_task),
        .o_last          (o_last)
    );

    // an accepted command blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not blocked after command accepted");

    // a word that is not last must report a fired task
    a_nonlast_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_fired)
        else $error("non-last word without fired task");

    // fired words are ok and never last
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fired) |-> (o_status == ptt_pkg::ST_OK && !o_last))
        else $error("fired word with bad status or last");

endmodule

// ===== design/ptt_ctrl.sv =====
module ptt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ptt_pkg::t_dp_stat i_stat,
    output ptt_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SRD    = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_DRD    = 4'd4;
    localparam logic [3:0] S_DWR    = 4'd5;
    localparam logic [3:0] S_RRD    = 4'd6;
    localparam logic [3:0] S_REVAL  = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_st;
    logic [1:0] n_st;

    assign o_stall = (r_state != S_IDLE);

    // state and pending status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ptt_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st    = ptt_pkg::ST_OK;
                n_state = S_RESP;
                unique case (i_stat.cmd) inside
                    ptt_pkg::CMD_ADD: begin
                        if (i_stat.per_zero) begin
                            n_st = ptt_pkg::ST_ZERO_PER;
                        end else if (i_stat.grp_full) begin
                            n_st = ptt_pkg::ST_FULL;
                        end else begin
                            o_cmd.add_write = 1'b1;
                        end
                    end
                    ptt_pkg::CMD_TICK: begin
                        o_cmd.tick = 1'b1;
                    end
                    ptt_pkg::CMD_RUN: begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_RRD;
                    end
                    ptt_pkg::CMD_CHANGE: begin
                        if (i_stat.per_zero) begin
                            n_st = ptt_pkg::ST_ZERO_PER;
                        end else begin
                            o_cmd.search_start = 1'b1;
                            n_state            = S_SRD;
                        end
                    end
                    ptt_pkg::CMD_ENABLE, ptt_pkg::CMD_DISABLE, ptt_pkg::CMD_DELETE: begin
                        o_cmd.search_start = 1'b1;
                        n_state            = S_SRD;
                    end
                    default: begin
                        n_st = ptt_pkg::ST_OK;
                    end
                endcase
            end
            // id search, high group then low group
            S_SRD: begin
                if (i_stat.pos_lt_end) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_SCMP;
                end else if (!i_stat.grp) begin
                    o_cmd.next_group = 1'b1;
                end else begin
                    n_st    = ptt_pkg::ST_NOT_FOUND;
                    n_state = S_RESP;
                end
            end
            S_SCMP: begin
                if (i_stat.match) begin
                    n_state = S_RESP;
                    unique case (i_stat.cmd) inside
                        ptt_pkg::CMD_ENABLE: begin
                            o_cmd.set_en   = 1'b1;
                            o_cmd.dl_rearm = 1'b1;
                        end
                        ptt_pkg::CMD_DISABLE: begin
                            o_cmd.clr_en = 1'b1;
                        end
                        ptt_pkg::CMD_CHANGE: begin
                            o_cmd.wr_period = 1'b1;
                        end
                        ptt_pkg::CMD_DELETE: begin
                            n_state = S_DRD;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            // delete: shift later entries down one slot
            S_DRD: begin
                if (i_stat.pos1_lt_end) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_DWR;
                end else begin
                    o_cmd.del_finish = 1'b1;
                    n_state          = S_RESP;
                end
            end
            S_DWR: begin
                o_cmd.del_move = 1'b1;
                o_cmd.pos_inc  = 1'b1;
                n_state        = S_DRD;
            end
            // run: walk the group and report due tasks
            S_RRD: begin
                if (i_stat.pos_lt_end) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_REVAL;
                end else begin
                    n_st    = ptt_pkg::ST_OK;
                    n_state = S_RESP;
                end
            end
            S_REVAL: begin
                if (!i_stat.due) begin
                    o_cmd.pos_inc = 1'b1;
                    n_state       = S_RRD;
                end else if (i_stat.out_free) begin
                    o_cmd.dl_rearm   = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ptt_pkg::ST_OK;
                    o_cmd.out_fired  = 1'b1;
                    o_cmd.out_last   = 1'b0;
                    o_cmd.pos_inc    = 1'b1;
                    n_state          = S_RRD;
                end
            end
            // closing word of the command
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_st;
                    o_cmd.out_fired  = 1'b0;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ptt_dp.sv =====
module ptt_dp #(
    parameter int HIGH_SLOTS  = 8,
    parameter int TOTAL_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptt_pkg::t_dp_cmd  i_cmd,
    output ptt_pkg::t_dp_stat o_stat,
    input  logic [2:0]        i_command,
    input  logic [7:0]        i_task_id,
    input  logic [31:0]       i_period,
    input  logic              i_priority_req,
    input  logic              i_start_enabled,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic              o_fired,
    output logic [7:0]        o_fired_task,
    output logic              o_last
);

    localparam int HI_CAP  = (HIGH_SLOTS < TOTAL_SLOTS) ? HIGH_SLOTS : TOTAL_SLOTS;
    localparam int LO_CAP  = TOTAL_SLOTS - HI_CAP;
    localparam int AW      = $clog2(TOTAL_SLOTS);
    localparam int CW      = $clog2(TOTAL_SLOTS + 1);
    localparam logic [CW-1:0] HI_CAP_C  = CW'(HI_CAP);
    localparam logic [CW-1:0] LO_CAP_C  = CW'(LO_CAP);
    localparam logic [CW-1:0] LO_BASE_C = CW'(HI_CAP);

    // entry stores
    logic [7:0]  r_mem_task [TOTAL_SLOTS];
    logic [31:0] r_mem_per  [TOTAL_SLOTS];
    logic [31:0] r_mem_dl   [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] r_en_vec;

    // scalar state
    logic [CW-1:0] r_high_cnt;
    logic [CW-1:0] r_low_cnt;
    logic [31:0]   r_time;

    // latched input word
    logic [2:0]  r_cmd;
    logic [7:0]  r_id;
    logic [31:0] r_per;
    logic        r_pri;
    logic        r_start_en;

    // walk position and read data
    logic          r_grp;
    logic [CW-1:0] r_pos;
    logic [7:0]    r_rd_task;
    logic [31:0]   r_rd_per;
    logic [31:0]   r_rd_dl;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic        r_out_fired;
    logic [7:0]  r_out_task;
    logic        r_out_last;

    logic [CW-1:0] grp_end;
    logic [CW:0]   pos_p1;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] pos1_idx;
    logic [CW-1:0] add_slot;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;
    logic [31:0]   diff;
    logic [31:0]   rearm_dl;
    logic          out_free;
    logic          we_task;
    logic          we_per;
    logic          we_dl;
    logic [7:0]    wd_task;
    logic [31:0]   wd_per;
    logic [31:0]   wd_dl;

    // address and compare logic
    assign grp_end  = r_grp ? (LO_BASE_C + r_low_cnt) : r_high_cnt;
    assign pos_p1   = {1'b0, r_pos} + (CW + 1)'(1);
    assign pos_idx  = r_pos[AW-1:0];
    assign pos1_idx = pos_p1[AW-1:0];
    assign add_slot = r_pri ? (LO_BASE_C + r_low_cnt) : r_high_cnt;
    assign wr_idx   = i_cmd.add_write ? add_slot[AW-1:0] : pos_idx;
    assign rd_idx   = i_cmd.rd_next ? pos1_idx : pos_idx;
    assign diff     = r_time - r_rd_dl;
    assign rearm_dl = r_time + r_rd_per;
    assign out_free = !r_out_valid || !i_stall;

    assign o_stat.cmd         = r_cmd;
    assign o_stat.per_zero    = (r_per == 32'd0);
    assign o_stat.grp_full    = r_pri ? (r_low_cnt >= LO_CAP_C) : (r_high_cnt >= HI_CAP_C);
    assign o_stat.grp         = r_grp;
    assign o_stat.pos_lt_end  = (r_pos < grp_end);
    assign o_stat.pos1_lt_end = (pos_p1 < {1'b0, grp_end});
    assign o_stat.match       = (r_rd_task == r_id);
    assign o_stat.due         = r_en_vec[pos_idx] && !diff[31];
    assign o_stat.out_free    = out_free;

    // write port selection
    always_comb begin
        we_task = i_cmd.add_write || i_cmd.del_move;
        we_per  = i_cmd.add_write || i_cmd.del_move || i_cmd.wr_period;
        we_dl   = i_cmd.add_write || i_cmd.del_move || i_cmd.dl_rearm;
        wd_task = i_cmd.add_write ? r_id : r_rd_task;
        wd_per  = i_cmd.del_move ? r_rd_per : r_per;
        if (i_cmd.add_write) begin
            wd_dl = r_time + r_per;
        end else if (i_cmd.del_move) begin
            wd_dl = r_rd_dl;
        end else begin
            wd_dl = rearm_dl;
        end
    end

    // entry memories, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (we_task) begin
            r_mem_task[wr_idx] <= wd_task;
        end
        if (we_per) begin
            r_mem_per[wr_idx] <= wd_per;
        end
        if (we_dl) begin
            r_mem_dl[wr_idx] <= wd_dl;
        end
        if (i_cmd.rd_issue || i_cmd.rd_next) begin
            r_rd_task <= r_mem_task[rd_idx];
            r_rd_per  <= r_mem_per[rd_idx];
            r_rd_dl   <= r_mem_dl[rd_idx];
        end
    end

    // enable bits, group counts and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_vec   <= '0;
            r_high_cnt <= '0;
            r_low_cnt  <= '0;
            r_time     <= '0;
        end else begin
            if (i_cmd.add_write) begin
                r_en_vec[wr_idx] <= r_start_en;
                if (r_pri) begin
                    r_low_cnt <= r_low_cnt + CW'(1);
                end else begin
                    r_high_cnt <= r_high_cnt + CW'(1);
                end
            end
            if (i_cmd.set_en) begin
                r_en_vec[pos_idx] <= 1'b1;
            end
            if (i_cmd.clr_en || i_cmd.del_finish) begin
                r_en_vec[pos_idx] <= 1'b0;
            end
            if (i_cmd.del_move) begin
                r_en_vec[pos_idx] <= r_en_vec[pos1_idx];
            end
            if (i_cmd.del_finish) begin
                if (r_grp) begin
                    r_low_cnt <= r_low_cnt - CW'(1);
                end else begin
                    r_high_cnt <= r_high_cnt - CW'(1);
                end
            end
            if (i_cmd.tick) begin
                r_time <= r_time + 32'd1;
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd      <= i_command;
            r_id       <= i_task_id;
            r_per      <= i_period;
            r_pri      <= i_priority_req;
            r_start_en <= i_start_enabled;
        end
    end

    // walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_grp <= 1'b0;
            r_pos <= '0;
        end else if (i_cmd.next_group) begin
            r_grp <= 1'b1;
            r_pos <= LO_BASE_C;
        end else if (i_cmd.run_start) begin
            r_grp <= r_pri;
            r_pos <= r_pri ? LO_BASE_C : '0;
        end else if (i_cmd.pos_inc) begin
            r_pos <= pos_p1[CW-1:0];
        end
    end

    // output register, frees on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_fired  <= i_cmd.out_fired;
            r_out_task   <= i_cmd.out_fired ? r_rd_task : 8'd0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_fired      = r_out_fired;
    assign o_fired_task = r_out_task;
    assign o_last       = r_out_last;

endmodule

// ===== verif/tb.sv =====
module tb;

    localparam int HIGH_SLOTS  = 8;
    localparam int TOTAL_SLOTS = 16;
    localparam int HI_CAP  = (HIGH_SLOTS < TOTAL_SLOTS) ? HIGH_SLOTS : TOTAL_SLOTS;
    localparam int LO_BASE = HI_CAP;
    localparam int LO_CAP  = TOTAL_SLOTS - HI_CAP;

    // command 7 has no package name, it is a no-op answering ok
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_PHASES    = 4;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int SETTLE_CYCLES    = 40;
    localparam int REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [1:0] status;
        logic       fired;
        logic [7:0] fired_task;
        logic       last;
    } t_result;

    // one row of the directed plan, repeated reps times with the id stepping
    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  id;
        logic [31:0] per;
        logic        pri;
        logic        en;
        int          reps;
        bit          typed;
        logic [1:0]  status;
    } t_plan_row;

    localparam int PLAN_ROWS = 31;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [2:0]  i_command = ptt_pkg::CMD_TICK;
    logic [7:0]  i_task_id = 8'h00;
    logic [31:0] i_period = 32'h0;
    logic        i_priority_req = 1'b0;
    logic        i_start_enabled = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [7:0]  o_fired_task;
    logic        o_last;

    // shadow of the task table
    logic [7:0]  slot_id       [TOTAL_SLOTS];
    logic [31:0] slot_period   [TOTAL_SLOTS];
    logic [31:0] slot_deadline [TOTAL_SLOTS];
    bit          slot_en       [TOTAL_SLOTS];
    int          hi_used = 0;
    int          lo_used = 0;
    logic [31:0] now_ticks = 32'h0;

    t_result cmd_words[$];      // words caused by the command just taken
    t_result pending_words[$];  // words still owed by the block

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit holding       = 1'b0;
    int mismatches    = 0;
    int words_checked = 0;
    int fired_seen    = 0;
    int cmds_sent     = 0;
    event hold_off_go;

    t_plan_row plan [PLAN_ROWS] = '{
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b1, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ENABLE,  8'h05, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1,
          ptt_pkg::ST_NOT_FOUND},
        '{ptt_pkg::CMD_DISABLE, 8'h05, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1,
          ptt_pkg::ST_NOT_FOUND},
        '{ptt_pkg::CMD_DELETE,  8'h05, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1,
          ptt_pkg::ST_NOT_FOUND},
        '{ptt_pkg::CMD_CHANGE,  8'h05, 32'h0000_000A, 1'b0, 1'b0, 1, 1'b1,
          ptt_pkg::ST_NOT_FOUND},
        '{ptt_pkg::CMD_CHANGE,  8'h05, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1,
          ptt_pkg::ST_ZERO_PER},
        '{ptt_pkg::CMD_ADD,     8'h01, 32'h0000_0000, 1'b0, 1'b1, 1, 1'b1,
          ptt_pkg::ST_ZERO_PER},
        '{ptt_pkg::CMD_ADD,     8'h00, 32'h0000_0001, 1'b0, 1'b1, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'h00, 32'h0000_0002, 1'b1, 1'b1, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'hAA, 32'h8000_0000, 1'b1, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b1, 1'b0, 1, 1'b0, ptt_pkg::ST_OK},
        '{CMD_UNUSED,           8'h55, 32'h5555_5555, 1'b1, 1'b1, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ENABLE,  8'hAA, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_CHANGE,  8'h00, 32'h0000_0003, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'h10, 32'h0000_0001, 1'b0, 1'b1, 6, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'h20, 32'h0000_0001, 1'b0, 1'b1, 1, 1'b1, ptt_pkg::ST_FULL},
        '{ptt_pkg::CMD_ADD,     8'h30, 32'h0000_0001, 1'b1, 1'b1, 6, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_ADD,     8'h3F, 32'h0000_0000, 1'b1, 1'b1, 1, 1'b1,
          ptt_pkg::ST_ZERO_PER},
        '{ptt_pkg::CMD_ADD,     8'h40, 32'h0000_0001, 1'b1, 1'b0, 1, 1'b1, ptt_pkg::ST_FULL},
        '{ptt_pkg::CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, 3, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b1, 1'b0, 1, 1'b0, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_DELETE,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_DISABLE, 8'h12, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_DELETE,  8'h35, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b1, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, ptt_pkg::ST_OK},
        '{ptt_pkg::CMD_RUN,     8'h00, 32'h0000_0000, 1'b1, 1'b0, 1, 1'b0, ptt_pkg::ST_OK}
    };

    periodic_task_timer_table_top #(
        .HIGH_SLOTS  (HIGH_SLOTS),
        .TOTAL_SLOTS (TOTAL_SLOTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_task_id       (i_task_id),
        .i_period        (i_period),
        .i_priority_req  (i_priority_req),
        .i_start_enabled (i_start_enabled),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_fired         (o_fired),
        .o_fired_task    (o_fired_task),
        .o_last          (o_last)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    // first slot holding id, high group searched first
    function automatic int find_slot(input logic [7:0] id, output bit in_low);
        in_low = 1'b0;
        for (int i = 0; i < hi_used && i < HI_CAP; i++)
            if (slot_id[i] == id) return i;
        in_low = 1'b1;
        for (int i = 0; i < lo_used && i < LO_CAP; i++)
            if (slot_id[LO_BASE + i] == id) return LO_BASE + i;
        return -1;
    endfunction

    // apply one command to the shadow table and collect the words it causes
    task automatic apply_command(input logic [2:0] cmd, input logic [7:0] id,
                                 input logic [31:0] per, input logic pri,
                                 input logic en);
        int          slot;
        int          stop;
        int          base;
        int          cnt;
        int          cap;
        bit          in_low;
        logic [31:0] lag;
        logic [1:0]  status;
        cmd_words.delete();
        status = ptt_pkg::ST_OK;
        if (cmd == ptt_pkg::CMD_RUN) begin
            base = pri ? LO_BASE : 0;
            cnt  = pri ? lo_used : hi_used;
            cap  = pri ? LO_CAP : HI_CAP;
            // walk the group, due when signed lag is not negative
            for (int i = 0; i < cnt && i < cap; i++) begin
                slot = base + i;
                lag  = now_ticks - slot_deadline[slot];
                if (slot_en[slot] && !lag[31]) begin
                    slot_deadline[slot] = now_ticks + slot_period[slot];
                    cmd_words.push_back({ptt_pkg::ST_OK, 1'b1, slot_id[slot], 1'b0});
                end
            end
        end else begin
            case (cmd)
                ptt_pkg::CMD_ADD: begin
                    if (per == 32'h0) begin
                        status = ptt_pkg::ST_ZERO_PER;
                    end else if ((!pri && hi_used >= HI_CAP) || (pri && lo_used >= LO_CAP)) begin
                        status = ptt_pkg::ST_FULL;
                    end else begin
                        slot = pri ? LO_BASE + lo_used : hi_used;
                        if (pri) lo_used++;
                        else hi_used++;
                        slot_id[slot]       = id;
                        slot_period[slot]   = per;
                        slot_deadline[slot] = now_ticks + per;
                        slot_en[slot]       = en;
                    end
                end
                ptt_pkg::CMD_ENABLE, ptt_pkg::CMD_DISABLE, ptt_pkg::CMD_DELETE,
                ptt_pkg::CMD_CHANGE: begin
                    slot = find_slot(id, in_low);
                    if (cmd == ptt_pkg::CMD_CHANGE && per == 32'h0) begin
                        status = ptt_pkg::ST_ZERO_PER;
                    end else if (slot < 0) begin
                        status = ptt_pkg::ST_NOT_FOUND;
                    end else if (cmd == ptt_pkg::CMD_ENABLE) begin
                        slot_en[slot]       = 1'b1;
                        slot_deadline[slot] = now_ticks + slot_period[slot];
                    end else if (cmd == ptt_pkg::CMD_DISABLE) begin
                        slot_en[slot] = 1'b0;
                    end else if (cmd == ptt_pkg::CMD_CHANGE) begin
                        slot_period[slot] = per;
                    end else begin
                        // delete closes the gap within the group
                        stop = in_low ? LO_BASE + lo_used : hi_used;
                        while (slot + 1 < stop) begin
                            slot_id[slot]       = slot_id[slot + 1];
                            slot_period[slot]   = slot_period[slot + 1];
                            slot_deadline[slot] = slot_deadline[slot + 1];
                            slot_en[slot]       = slot_en[slot + 1];
                            slot++;
                        end
                        slot_en[slot] = 1'b0;
                        if (in_low) lo_used--;
                        else hi_used--;
                    end
                end
                ptt_pkg::CMD_TICK: begin
                    now_ticks = now_ticks + 32'd1;
                end
                default: begin
                end
            endcase
        end
        cmd_words.push_back({status, 1'b0, 8'h00, 1'b1});
    endtask

    // offer one command word and book what it owes once taken
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] id,
                             input logic [31:0] per, input logic pri,
                             input logic en, input bit typed,
                             input logic [1:0] typed_status);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_task_id       <= id;
        i_period        <= per;
        i_priority_req  <= pri;
        i_start_enabled <= en;
        do @(posedge i_clk); while (o_stall);
        apply_command(cmd, id, per, pri, en);
        if (typed) begin
            pending_words.push_back({typed_status, 1'b0, 8'h00, 1'b1});
        end else begin
            foreach (cmd_words[k]) pending_words.push_back(cmd_words[k]);
        end
        cmds_sent++;
    endtask

    // random command, ids drawn mostly from a small pool so searches hit
    task automatic send_random();
        int          pick;
        logic [2:0]  cmd;
        logic [7:0]  id;
        logic [31:0] per;
        pick = $urandom_range(99);
        if (pick < 18)      cmd = ptt_pkg::CMD_ADD;
        else if (pick < 28) cmd = ptt_pkg::CMD_ENABLE;
        else if (pick < 36) cmd = ptt_pkg::CMD_DISABLE;
        else if (pick < 51) cmd = ptt_pkg::CMD_DELETE;
        else if (pick < 59) cmd = ptt_pkg::CMD_CHANGE;
        else if (pick < 78) cmd = ptt_pkg::CMD_TICK;
        else if (pick < 98) cmd = ptt_pkg::CMD_RUN;
        else                cmd = CMD_UNUSED;
        id = ($urandom_range(99) < 85) ? 8'($urandom_range(23)) : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)      per = 32'($urandom_range(6, 1));
        else if (pick < 85) per = $urandom;
        else if (pick < 90) per = 32'h0;
        else                per = 32'h8000_0000 + 32'($urandom_range(4)) - 32'd2;
        send_word(cmd, id, per, 1'($urandom), 1'($urandom), 1'b0, ptt_pkg::ST_OK);
    endtask

    // stop offering until every owed word is back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= holding || ($urandom_range(99) < rx_stall_pct);
    end

    // long receiver hold-off
    initial begin
        forever begin
            @(hold_off_go);
            holding = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    // compare each taken result word with the oldest owed one
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_fired, o_fired_task, o_last};
            words_checked++;
            if (got.fired) fired_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: status %0d fired %0b task %02h last %0b",
                             got.status, got.fired, got.fired_task, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("word %0d: expected status %0d fired %0b task %02h last %0b,",
                                 words_checked, want.status, want.fired, want.fired_task,
                                 want.last,
                                 " got status %0d fired %0b task %02h last %0b",
                                 got.status, got.fired, got.fired_task, got.last);
                end
            end
        end
    end

    // stimulus
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan[r]) begin
            for (int n = 0; n < plan[r].reps; n++)
                send_word(plan[r].cmd, plan[r].id + 8'(n), plan[r].per, plan[r].pri,
                          plan[r].en, plan[r].typed, plan[r].status);
        end
        drain_results();

        // random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 10) -> hold_off_go;
                if (n == ITEMS_PER_PHASE / 2) drain_results();
                send_random();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d commands over directed and four random phases", cmds_sent);
        $display("checked %0d result words, %0d of them fired tasks", words_checked, fired_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
